// ===== sv/gmps_pkg.sv =====
// gmps_pkg: shared constants, register codes and types for grid_max_path_sum
// no dependencies; imported by the line buffer, the path core and the top level
`timescale 1ns / 1ps

package gmps_pkg;

  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;

  localparam int CELL_W = 16;
  localparam int SUM_W  = 23;
  localparam int DIM_W  = 8;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int IDX_W  = 1;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};
  localparam logic [DIM_W-1:0] DIM_MAX_W = DIM_W'(MAX_WIDTH);
  localparam logic [DIM_W-1:0] DIM_MAX_H = DIM_W'(MAX_HEIGHT);

  typedef enum logic [IDX_W-1:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_index_t;

  // grid geometry handed from the register file to the path core
  typedef struct packed {
    logic [DIM_W-1:0] width;
    logic [DIM_W-1:0] height;
    logic             restart;
  } grid_cfg_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                 input logic [DIM_W-1:0] maxv);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > maxv) begin
      r = maxv;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ===== sv/gmps_line_buf.sv =====
// gmps_line_buf: one-row buffer of best path sums, one write and one read port
// read data is registered and sees a same-cycle write; uses gmps_pkg
`timescale 1ns / 1ps

module gmps_line_buf (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [gmps_pkg::COL_W-1:0] wr_addr,
  input  logic [gmps_pkg::SUM_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [gmps_pkg::COL_W-1:0] rd_addr,
  output logic [gmps_pkg::SUM_W-1:0] rd_data
);
  import gmps_pkg::*;

  logic [SUM_W-1:0] mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else begin
        rd_data <= mem[rd_addr];
      end
    end
  end

endmodule

// ===== sv/gmps_path_core.sv =====
// gmps_path_core: per-cell path sum update, column/row tracking, final-row maximum
// uses gmps_pkg and gmps_line_buf
`timescale 1ns / 1ps

module gmps_path_core (
  input  logic                       clk,
  input  logic                       rst,
  input  gmps_pkg::grid_cfg_t        cfg,
  input  logic                       fire,
  input  logic [gmps_pkg::CELL_W-1:0] cell_value,
  output logic                       last_cell,
  output logic                       res_valid,
  output logic [gmps_pkg::SUM_W-1:0]  res_sum
);
  import gmps_pkg::*;

  logic [COL_W-1:0] col;
  logic [ROW_W-1:0] row;
  logic [SUM_W-1:0] left_sum;
  logic [SUM_W-1:0] up_sum;
  logic [SUM_W-1:0] first_sum;
  logic [SUM_W-1:0] running_best;
  logic [SUM_W-1:0] right_sum;

  logic             col_last;
  logic             row_last;
  logic             has_right;
  logic [SUM_W-1:0] nbr_max;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] best_next;
  logic [COL_W-1:0] rd_addr;

  assign col_last  = ({1'b0, col} + DIM_W'(1)) == cfg.width;
  assign row_last  = ({1'b0, row} + DIM_W'(1)) == cfg.height;
  assign has_right = !col_last;
  assign last_cell = col_last && row_last;

  always_comb begin
    nbr_max = up_sum;
    if ((col != '0) && (left_sum > nbr_max)) begin
      nbr_max = left_sum;
    end
    if (has_right && (right_sum > nbr_max)) begin
      nbr_max = right_sum;
    end
    sum_wide = {1'b0, nbr_max} + (SUM_W+1)'(cell_value);
    if (row == '0) begin
      sum = SUM_W'(cell_value);
    end else if (sum_wide[SUM_W]) begin
      sum = SUM_MAX;
    end else begin
      sum = sum_wide[SUM_W-1:0];
    end
    best_next = ((col == '0) || (sum > running_best)) ? sum : running_best;
  end

  // prefetch the up-right sum for the next cell: two columns ahead, or column 1 at a wrap
  assign rd_addr = col_last ? COL_W'(1) : COL_W'({1'b0, col} + (COL_W+1)'(2));

  gmps_line_buf u_line_buf (
    .clk     (clk),
    .wr_en   (fire),
    .wr_addr (col),
    .wr_data (sum),
    .rd_en   (fire),
    .rd_addr (rd_addr),
    .rd_data (right_sum)
  );

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      col          <= '0;
      row          <= '0;
      left_sum     <= '0;
      running_best <= '0;
    end else if (fire) begin
      if (row_last) begin
        running_best <= best_next;
      end
      if (col_last) begin
        col      <= '0;
        left_sum <= '0;
        if (row_last) begin
          row          <= '0;
          running_best <= '0;
        end else begin
          row <= row + ROW_W'(1);
        end
      end else begin
        col      <= col + COL_W'(1);
        left_sum <= up_sum;
      end
    end
  end

  // payload: up neighbour for the next cell and the column-0 sum of this row
  always_ff @(posedge clk) begin
    if (fire) begin
      if (col == '0) begin
        first_sum <= sum;
      end
      if (col_last) begin
        up_sum <= (col == '0) ? sum : first_sum;
      end else begin
        up_sum <= right_sum;
      end
    end
  end

  assign res_valid = fire && last_cell;
  assign res_sum   = best_next;

endmodule

// ===== sv/grid_max_path_sum.sv =====
// grid_max_path_sum: top level with register file, path core and result register
// uses gmps_pkg and gmps_path_core
`timescale 1ns / 1ps

// Usage
//   cell channel (cell_valid/cell_ready/cell_value): grid cells in raster order,
//   row by row, left to right. One cell is taken every cycle unless a last cell waits.
//   result channel (result_valid/result_ready/best_sum): one result per grid,
//   the largest top-to-bottom path sum with up-left, up and up-right moves.
//   The result is registered and shows in the cycle after the grid's last cell is taken.
//   Throughput is one cell per cycle while no last cell waits; each cell needs one
//   line-buffer read (the up-right sum, fetched one cell ahead) plus a three-way max and an add.
//   cfg_write/cfg_index/cfg_data set grid_width (index 0) and grid_height
//   (index 1); zero counts as 1, values above the maximum saturate. A write
//   drops the grid in progress and the next cell starts a new grid.
//   Reset sets both dimensions to 1 and starts a new grid; the line buffer is
//   not cleared, every entry is written before a value read from it is used.
//   If result_ready stays low while a result is held, cells keep being taken
//   until the next grid's last cell, which waits until the result is taken.

module grid_max_path_sum (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [gmps_pkg::IDX_W-1:0]  cfg_index,
  input  logic [gmps_pkg::DIM_W-1:0]  cfg_data,
  input  logic                        cell_valid,
  output logic                        cell_ready,
  input  logic [gmps_pkg::CELL_W-1:0] cell_value,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [gmps_pkg::SUM_W-1:0]  best_sum
);
  import gmps_pkg::*;

  logic [DIM_W-1:0] grid_width;
  logic [DIM_W-1:0] grid_height;
  grid_cfg_t        cfg;
  logic             fire;
  logic             last_cell;
  logic             res_valid;
  logic [SUM_W-1:0] res_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= DIM_W'(1);
      grid_height <= DIM_W'(1);
    end else begin
      if (cfg_write) begin
        unique case (reg_index_t'(cfg_index))
          REG_GRID_WIDTH:  grid_width  <= clamp_dim(cfg_data, DIM_MAX_W);
          REG_GRID_HEIGHT: grid_height <= clamp_dim(cfg_data, DIM_MAX_H);
        endcase
      end
    end
  end

  // the grid restarts at the same edge as the register write
  assign cfg.width   = grid_width;
  assign cfg.height  = grid_height;
  assign cfg.restart = cfg_write;

  // only the last cell of a grid has to wait for the result register
  assign cell_ready = !result_valid || result_ready || !last_cell;
  assign fire       = cell_valid && cell_ready;

  gmps_path_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .fire       (fire),
    .cell_value (cell_value),
    .last_cell  (last_cell),
    .res_valid  (res_valid),
    .res_sum    (res_sum)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_valid) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      best_sum <= res_sum;
    end
  end

endmodule

// ===== sim/grid_max_path_sum_test.sv =====
// grid_max_path_sum_test: self-checking bench for grid_max_path_sum, random grids and sizes
// predicts best_sum per grid from its own line-buffer model; needs gmps_pkg and the rtl
`timescale 1ns / 1ps

module grid_max_path_sum_test;
  import gmps_pkg::*;

  // cell fill patterns
  localparam int unsigned FILL_MAX    = 0;
  localparam int unsigned FILL_ZERO   = 1;
  localparam int unsigned FILL_TINY   = 2;
  localparam int unsigned FILL_RANDOM = 3;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_write;
  logic [IDX_W-1:0]  cfg_index;
  logic [DIM_W-1:0]  cfg_data;
  logic              cell_valid = 1'b0;
  logic              cell_ready;
  logic [CELL_W-1:0] cell_value = '0;
  logic              result_valid;
  logic              result_ready = 1'b0;
  logic [SUM_W-1:0]  best_sum;

  grid_max_path_sum DUT (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .cell_valid(cell_valid), .cell_ready(cell_ready), .cell_value(cell_value),
    .result_valid(result_valid), .result_ready(result_ready), .best_sum(best_sum)
  );

  always #4 clk = ~clk;

  // cell values waiting to go out, best sums waiting to come back
  logic [CELL_W-1:0] pending_cells [$];
  logic [SUM_W-1:0]  expected_best [$];
  int unsigned cells_queued = 0;
  int unsigned cells_accepted = 0;
  int unsigned mismatch_count = 0;
  int unsigned idle_pct = 0;
  logic        hold_req = 1'b0;
  logic        hold_ack = 1'b0;

  // path-sum model state
  logic [SUM_W-1:0] line_sums [MAX_WIDTH];
  logic [SUM_W-1:0] left_above;
  logic [SUM_W-1:0] best_so_far;
  int unsigned      col, row;
  logic [DIM_W-1:0] width_reg, height_reg;

  function automatic int unsigned dim_in_use(input logic [DIM_W-1:0] v, input int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  task automatic restart_grid();
    left_above = '0;
    best_so_far = '0;
    col = 0;
    row = 0;
  endtask

  task automatic take_cell(input logic [CELL_W-1:0] value);
    int unsigned w, h, c, r, up, right, best, total;
    logic [SUM_W-1:0] sum;
    w = dim_in_use(width_reg, MAX_WIDTH);
    h = dim_in_use(height_reg, MAX_HEIGHT);
    c = (col >= w) ? w - 1 : col;
    r = (row >= h) ? h - 1 : row;
    if (r == 0) begin
      sum = SUM_W'(value);
    end else begin
      up = line_sums[c];
      best = up;
      if (c > 0 && left_above > best) best = left_above;
      if (c + 1 < w) begin
        right = line_sums[c + 1];
        if (right > best) best = right;
      end
      // the entry above is about to be overwritten; keep it for the next column
      left_above = SUM_W'(up);
      total = value + best;
      sum = (total > SUM_MAX) ? SUM_MAX : SUM_W'(total);
    end
    line_sums[c] = sum;
    if (r + 1 == h && (c == 0 || sum > best_so_far)) best_so_far = sum;
    if (c + 1 < w) begin
      col = c + 1;
    end else begin
      col = 0;
      left_above = '0;
      if (r + 1 < h) begin
        row = r + 1;
      end else begin
        expected_best.insert(expected_best.size(), best_so_far);
        restart_grid();
      end
    end
  endtask

  // sender: one transfer per accepted cell, random bursts of idle cycles
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    if (rst) begin
      cell_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (cell_valid && cell_ready) begin
        take_cell(cell_value);
        cells_accepted++;
      end
      if (!cell_valid || cell_ready) begin
        if (send_gap != 0) begin
          cell_valid <= 1'b0;
          send_gap <= send_gap - 1;
        end else if (pending_cells.size() == 0) begin
          cell_valid <= 1'b0;
        end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
          cell_valid <= 1'b0;
          send_gap <= $urandom_range(0, 18);
        end else begin
          cell_valid <= 1'b1;
          cell_value <= pending_cells.pop_front();
        end
      end
    end
  end

  // receiver: checks each result transfer, stalls in bursts or on a long hold
  int unsigned stall_left = 0;
  int unsigned hold_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_best.size() == 0) begin
          $display("%0t: unexpected best_sum, expected none, got %0d", $time, best_sum);
          mismatch_count++;
        end else begin
          if (best_sum !== expected_best[0]) begin
            $display("%0t: best_sum mismatch, expected %0d, got %0d",
                     $time, expected_best[0], best_sum);
            mismatch_count++;
          end
          void'(expected_best.pop_front());
        end
      end
      if (hold_req != hold_ack) begin
        hold_ack <= hold_req;
        hold_left <= 300;
        result_ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        result_ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        result_ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        stall_left <= $urandom_range(0, 18);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  task automatic push_cell(input logic [CELL_W-1:0] v);
    pending_cells.insert(pending_cells.size(), v);
    cells_queued++;
  endtask

  // max, zero, tiny values for ties, else full range
  task automatic queue_cells(input int unsigned count, input int unsigned fill);
    for (int unsigned i = 0; i < count; i++) begin
      case (fill)
        FILL_MAX:  push_cell('1);
        FILL_ZERO: push_cell('0);
        FILL_TINY: push_cell(CELL_W'($urandom_range(3)));
        default:   push_cell(CELL_W'($urandom));
      endcase
    end
  endtask

  task automatic drain();
    do @(posedge clk);
    while (cells_accepted != cells_queued || expected_best.size() != 0);
    // a dropped partial grid leaves nothing to wait for, so pad the wait after it
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(input bit set_w, input logic [DIM_W-1:0] w_val,
                           input bit set_h, input logic [DIM_W-1:0] h_val);
    if (set_w) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_GRID_WIDTH;
      cfg_data <= w_val;
      @(posedge clk);
      width_reg = w_val;
      restart_grid();
    end
    if (set_h) begin
      cfg_write <= 1'b1;
      cfg_index <= REG_GRID_HEIGHT;
      cfg_data <= h_val;
      @(posedge clk);
      height_reg = h_val;
      restart_grid();
    end
    cfg_write <= 1'b0;
  endtask

  function automatic logic [DIM_W-1:0] pick_dim();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 6) return '0;
    if (r < 12) return DIM_W'(128);
    if (r < 16) return DIM_W'($urandom_range(129, 255));
    return DIM_W'($urandom_range(1, 8));
  endfunction

  initial begin
    bit set_w, set_h;
    logic [DIM_W-1:0] w_val, h_val;
    int unsigned ew, eh, cells, grids, max_grids;

    cfg_write <= 1'b0;
    cfg_index <= REG_GRID_WIDTH;
    cfg_data <= '0;
    for (int i = 0; i < MAX_WIDTH; i++) line_sums[i] = '0;
    width_reg = DIM_W'(1);
    height_reg = DIM_W'(1);
    restart_grid();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // default 1x1 grid: every cell is a grid of its own
    push_cell('0);
    push_cell('1);
    push_cell(CELL_W'(1));
    drain();
    // 3x2 with extremes at both edges
    configure(1, DIM_W'(3), 1, DIM_W'(2));
    push_cell('1); push_cell('0); push_cell(CELL_W'(1));
    push_cell('0); push_cell('1); push_cell(CELL_W'(2));
    drain();
    // partial grid, then a write drops it; width zero counts as one
    queue_cells(4, FILL_RANDOM);
    drain();
    configure(1, '0, 1, DIM_W'(3));
    push_cell(CELL_W'(5)); push_cell('0); push_cell('1);
    drain();
    // tiny values, so that equal sums are common
    configure(1, DIM_W'(2), 1, DIM_W'(2));
    queue_cells(4, FILL_TINY);
    drain();
    // height zero counts as one
    configure(0, '0, 1, '0);
    push_cell('1); push_cell('1);
    drain();

    // tallest grid of maximum values: the largest possible sum
    idle_pct <= 20;
    configure(1, DIM_W'(1), 1, DIM_W'(128));
    queue_cells(128, FILL_MAX);
    drain();
    // widest grid, width saturated from an oversized value
    configure(1, '1, 1, DIM_W'(2));
    queue_cells(256, FILL_RANDOM);
    drain();

    // long receiver hold: small grids fill the block until it stalls its input
    idle_pct <= 0;
    configure(1, DIM_W'(2), 1, DIM_W'(1));
    hold_req <= ~hold_req;
    queue_cells(60, FILL_RANDOM);
    drain();

    while (cells_queued < 860) begin
      case ($urandom_range(3))
        0: idle_pct <= 0;
        1: idle_pct <= 5;
        2: idle_pct <= 20;
        default: idle_pct <= 50;
      endcase
      set_w = 0;
      set_h = 0;
      if ($urandom_range(4) != 0) begin
        set_w = $urandom_range(2) != 0;
        set_h = !set_w || $urandom_range(2) != 0;
      end
      w_val = pick_dim();
      h_val = pick_dim();
      ew = dim_in_use(set_w ? w_val : width_reg, MAX_WIDTH);
      eh = dim_in_use(set_h ? h_val : height_reg, MAX_HEIGHT);
      if (ew * eh > 260) begin
        set_h = 1;
        h_val = DIM_W'($urandom_range(1, 2));
        eh = h_val;
      end
      configure(set_w, w_val, set_h, h_val);
      cells = ew * eh;
      max_grids = (cells >= 40) ? 1 : 40 / cells;
      if (max_grids > 6) max_grids = 6;
      grids = $urandom_range(1, max_grids);
      for (int unsigned g = 0; g < grids; g++) begin
        queue_cells(cells, $urandom_range(9));
      end
      // sometimes leave a grid unfinished for the next write to drop
      if (cells > 1 && $urandom_range(5) == 0) begin
        queue_cells($urandom_range(1, cells - 1), FILL_RANDOM);
      end
      drain();
    end

    // quiet tail: no idling on either side
    idle_pct <= 0;
    configure(1, DIM_W'(4), 1, DIM_W'(3));
    for (int unsigned g = 0; g < 8; g++) queue_cells(12, $urandom_range(9));
    drain();
    repeat (10) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
